FILE: src/bhp_pkg.sv
// shared types, constants and helper function of the bitstream header parser
`timescale 1ns / 1ps
package bhp_pkg;

    localparam int POSITION_BITS  = 32;
    localparam int LEN_BITS       = 32;
    localparam int MIN_LEN_BITS   = 16;
    localparam int OFFSET_BITS    = 32;
    localparam int CMP_BITS       = ((POSITION_BITS > LEN_BITS) ? POSITION_BITS : LEN_BITS) + 1;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int MAGIC_LEN      = 13;
    localparam int MAGIC_IDX_BITS = $clog2(MAGIC_LEN);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_LENGTH     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_IMAGE_LENGTH = 2'd1;

    localparam logic [MIN_LEN_BITS-1:0] MIN_LEN_RESET = 16'd4096;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_WARN  = 2'd1;
    localparam logic [1:0] KIND_SYNC  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [1:0] ERR_BAD_MAGIC      = 2'd0;
    localparam logic [1:0] ERR_TOO_SMALL      = 2'd1;
    localparam logic [1:0] ERR_NO_FILLER      = 2'd2;
    localparam logic [1:0] ERR_UNEXPECTED_END = 2'd3;

    localparam logic [7:0] BYTE_NUL      = 8'h00;
    localparam logic [7:0] BYTE_FILLER   = 8'hff;
    localparam logic [7:0] BYTE_SYNC     = 8'haa;
    localparam logic [7:0] BYTE_SYNC_END = 8'h99;
    localparam logic [7:0] CHAR_A        = 8'h61;
    localparam logic [7:0] CHAR_B        = 8'h62;
    localparam logic [7:0] CHAR_D        = 8'h64;
    localparam logic [7:0] CHAR_E        = 8'h65;
    localparam logic [7:0] CHAR_S        = 8'h73;
    localparam logic [7:0] CHAR_3        = 8'h33;

    typedef struct packed {
        logic [7:0]               data;
        logic [POSITION_BITS-1:0] pos;
        logic                     magic_ok;
        logic                     magic_last;
        logic                     too_small;
        logic                     pos_ge;
        logic                     prev_ge;
        logic                     next_ge;
    } t_item;

    typedef struct packed {
        logic [1:0]             kind;
        logic [1:0]             field_id;
        logic [7:0]             value;
        logic [1:0]             error_code;
        logic [OFFSET_BITS-1:0] sync_offset;
    } t_result;

    typedef struct packed {
        logic [QUEUE_PTR_BITS:0] count;
        logic                    full;
        logic                    empty;
    } t_queue_status;

    function automatic logic [7:0] magic_byte(input logic [MAGIC_IDX_BITS-1:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h00;
            4'd1:    b = 8'h09;
            4'd2:    b = 8'h0f;
            4'd3:    b = 8'hf0;
            4'd4:    b = 8'h0f;
            4'd5:    b = 8'hf0;
            4'd6:    b = 8'h0f;
            4'd7:    b = 8'hf0;
            4'd8:    b = 8'h0f;
            4'd9:    b = 8'hf0;
            4'd10:   b = 8'h00;
            4'd11:   b = 8'h00;
            4'd12:   b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: src/bhp_if.sv
// handshake channels of the bitstream header parser: bytes, results, config writes
`timescale 1ns / 1ps
interface bhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface bhp_result_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       kind;
    logic [1:0]                       field_id;
    logic [7:0]                       value;
    logic [1:0]                       error_code;
    logic [bhp_pkg::OFFSET_BITS-1:0]  sync_offset;

    modport source (output valid, output kind, output field_id, output value,
                    output error_code, output sync_offset, input ready);
    modport sink (input valid, input kind, input field_id, input value,
                  input error_code, input sync_offset, output ready);
endinterface

interface bhp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bhp_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [bhp_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/bhp_front.sv
// front end: takes bytes, tags them with position and classifies them against config
`timescale 1ns / 1ps
module bhp_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    bhp_byte_if.sink               i_byte_ch,
    bhp_cfg_if.sink                i_cfg_ch,
    input  bhp_pkg::t_queue_status i_q_status,
    output logic                   o_push,
    output bhp_pkg::t_item         o_item
);
    import bhp_pkg::*;

    logic [POSITION_BITS-1:0] r_pos;
    logic [LEN_BITS-1:0]      r_image_length;
    logic [MIN_LEN_BITS-1:0]  r_min_length;
    logic [POSITION_BITS-1:0] w_prev_pos;
    logic [CMP_BITS-1:0]      w_len_ext;

    assign i_byte_ch.ready = !i_q_status.full;
    assign i_cfg_ch.ready  = 1'b1;
    assign o_push          = i_byte_ch.valid && !i_q_status.full;

    assign w_prev_pos = r_pos - POSITION_BITS'(1);
    assign w_len_ext  = CMP_BITS'(r_image_length);

    always_comb begin
        o_item.data       = i_byte_ch.data_byte;
        o_item.pos        = r_pos;
        o_item.magic_ok   = (r_pos < POSITION_BITS'(MAGIC_LEN)) &&
                            (i_byte_ch.data_byte == magic_byte(r_pos[MAGIC_IDX_BITS-1:0]));
        o_item.magic_last = (r_pos == POSITION_BITS'(MAGIC_LEN - 1));
        o_item.too_small  = (CMP_BITS'(r_image_length) < CMP_BITS'(r_min_length));
        o_item.pos_ge     = (CMP_BITS'(r_pos) >= w_len_ext);
        o_item.prev_ge    = (CMP_BITS'(w_prev_pos) >= w_len_ext);
        o_item.next_ge    = ((CMP_BITS'(r_pos) + CMP_BITS'(1)) >= w_len_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= '0;
            r_image_length <= '0;
            r_min_length   <= MIN_LEN_RESET;
        end else begin
            if (o_push) begin
                r_pos <= r_pos + POSITION_BITS'(1);
            end
            if (i_cfg_ch.valid) begin
                case (i_cfg_ch.index)
                    CFG_IMAGE_LENGTH:     r_image_length <= LEN_BITS'(i_cfg_ch.data);
                    CFG_MIN_IMAGE_LENGTH: r_min_length   <= MIN_LEN_BITS'(i_cfg_ch.data);
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

FILE: src/bhp_queue.sv
// short queue of classified bytes between front end and parser
`timescale 1ns / 1ps
module bhp_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  bhp_pkg::t_item         i_item,
    input  logic                   i_pop,
    output bhp_pkg::t_item         o_item,
    output bhp_pkg::t_queue_status o_status
);
    import bhp_pkg::*;

    t_item                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_PTR_BITS:0]   r_count;

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.count = r_count;
    assign o_status.full  = (r_count == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_BITS'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QUEUE_PTR_BITS + 1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_PTR_BITS + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: src/bhp_back.sv
// back end: header parsing state machine and result output register
`timescale 1ns / 1ps
module bhp_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bhp_pkg::t_queue_status i_q_status,
    input  bhp_pkg::t_item         i_item,
    output logic                   o_pop,
    bhp_result_if.source           o_result_ch
);
    import bhp_pkg::*;

    localparam logic [3:0] PH_MAGIC = 4'd0;
    localparam logic [3:0] PH_TYPE  = 4'd1;
    localparam logic [3:0] PH_NUL   = 4'd2;
    localparam logic [3:0] PH_LEN   = 4'd3;
    localparam logic [3:0] PH_STR   = 4'd4;
    localparam logic [3:0] PH_E1    = 4'd5;
    localparam logic [3:0] PH_E2    = 4'd6;
    localparam logic [3:0] PH_E3    = 4'd7;
    localparam logic [3:0] PH_SCAN  = 4'd8;
    localparam logic [3:0] PH_SYNC  = 4'd9;
    localparam logic [3:0] PH_DONE  = 4'd10;

    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_record_kind, n_record_kind;
    logic [7:0]  r_remaining, n_remaining;
    logic [15:0] r_window, n_window;
    logic [1:0]  r_flags, n_flags;

    logic        r_out_valid;
    t_result     r_out;

    logic        w_has;
    t_result     w_res;
    logic        w_dec_has;
    t_result     w_dec_res;
    logic [3:0]  w_dec_phase;
    logic [7:0]  w_field;

    function automatic t_result make_err(input logic [1:0] code);
        t_result res;
        res            = '0;
        res.kind       = KIND_ERROR;
        res.error_code = code;
        return res;
    endfunction

    function automatic t_result make_sync(input logic [POSITION_BITS-1:0] pos);
        t_result res;
        res             = '0;
        res.kind        = KIND_SYNC;
        res.sync_offset = OFFSET_BITS'(pos);
        return res;
    endfunction

    assign o_pop   = !i_q_status.empty && (!r_out_valid || o_result_ch.ready);
    assign w_field = r_record_kind - CHAR_A;

    // end of the sync word scan
    always_comb begin
        w_dec_has   = 1'b1;
        w_dec_res   = '0;
        w_dec_phase = PH_DONE;
        if (r_flags[1]) begin
            if (i_item.data != BYTE_FILLER) begin
                w_dec_res = make_err(ERR_NO_FILLER);
            end else if (i_item.next_ge) begin
                w_dec_res = make_err(ERR_UNEXPECTED_END);
            end else begin
                w_dec_has   = 1'b0;
                w_dec_phase = PH_SYNC;
            end
        end else if (r_window[15:8] != BYTE_FILLER) begin
            w_dec_res = make_err(ERR_NO_FILLER);
        end else if (i_item.prev_ge) begin
            w_dec_res = make_err(ERR_UNEXPECTED_END);
        end else if (r_window[7:0] == BYTE_SYNC) begin
            w_dec_res = make_sync(i_item.pos - POSITION_BITS'(1));
        end else if (i_item.pos_ge) begin
            w_dec_res = make_err(ERR_UNEXPECTED_END);
        end else if (i_item.data == BYTE_SYNC) begin
            w_dec_res = make_sync(i_item.pos);
        end else if (i_item.next_ge) begin
            w_dec_res = make_err(ERR_UNEXPECTED_END);
        end else begin
            w_dec_has   = 1'b0;
            w_dec_phase = PH_SYNC;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_record_kind = r_record_kind;
        n_remaining   = r_remaining;
        n_flags       = r_flags;
        n_window      = {r_window[7:0], i_item.data};
        w_has         = 1'b0;
        w_res         = '0;
        case (r_phase)
            PH_MAGIC: begin
                if (!i_item.magic_ok) begin
                    w_has   = 1'b1;
                    w_res   = make_err(ERR_BAD_MAGIC);
                    n_phase = PH_DONE;
                end else if (i_item.magic_last) begin
                    if (i_item.too_small) begin
                        w_has   = 1'b1;
                        w_res   = make_err(ERR_TOO_SMALL);
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_TYPE;
                    end
                end
            end
            PH_TYPE: begin
                n_record_kind = i_item.data;
                if (i_item.data == CHAR_B) begin
                    n_flags = 2'b00;
                end
                n_phase = PH_NUL;
            end
            PH_NUL: begin
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_remaining = i_item.data;
                if (r_record_kind >= CHAR_A && r_record_kind <= CHAR_D) begin
                    n_phase = (i_item.data != BYTE_NUL) ? PH_STR : PH_TYPE;
                end else if (r_record_kind == CHAR_E) begin
                    n_phase = PH_E1;
                end else begin
                    w_has       = 1'b1;
                    w_res.kind  = KIND_WARN;
                    w_res.value = r_record_kind;
                    n_phase     = PH_TYPE;
                end
            end
            PH_STR: begin
                if (i_item.data == BYTE_NUL) begin
                    n_phase = PH_TYPE;
                end else begin
                    w_has          = 1'b1;
                    w_res.kind     = KIND_CHAR;
                    w_res.field_id = w_field[1:0];
                    w_res.value    = i_item.data;
                    if (r_record_kind == CHAR_B) begin
                        n_flags[1] = r_flags[1] || (r_flags[0] && i_item.data == CHAR_S);
                        n_flags[0] = (i_item.data == CHAR_3);
                    end
                    n_remaining = r_remaining - 8'd1;
                    if (r_remaining == 8'd1) begin
                        n_phase = PH_TYPE;
                    end
                end
            end
            PH_E1: begin
                n_phase = PH_E2;
            end
            PH_E2: begin
                n_phase = PH_E3;
            end
            PH_E3: begin
                if (r_remaining == 8'd0) begin
                    w_has   = w_dec_has;
                    w_res   = w_dec_res;
                    n_phase = w_dec_phase;
                end else begin
                    n_phase = PH_SCAN;
                end
            end
            PH_SCAN: begin
                if (r_remaining <= 8'd1 ||
                    (r_window == {BYTE_FILLER, BYTE_SYNC} && i_item.data == BYTE_SYNC_END)) begin
                    w_has   = w_dec_has;
                    w_res   = w_dec_res;
                    n_phase = w_dec_phase;
                end else begin
                    n_remaining = r_remaining - 8'd1;
                end
            end
            PH_SYNC: begin
                if (i_item.data == BYTE_SYNC) begin
                    w_has   = 1'b1;
                    w_res   = make_sync(i_item.pos);
                    n_phase = PH_DONE;
                end else if (i_item.next_ge) begin
                    w_has   = 1'b1;
                    w_res   = make_err(ERR_UNEXPECTED_END);
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_MAGIC;
            r_record_kind <= '0;
            r_remaining   <= '0;
            r_window      <= '0;
            r_flags       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase       <= n_phase;
                r_record_kind <= n_record_kind;
                r_remaining   <= n_remaining;
                r_window      <= n_window;
                r_flags       <= n_flags;
                r_out_valid   <= w_has;
            end else if (o_result_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_has) begin
            r_out <= w_res;
        end
    end

    assign o_result_ch.valid       = r_out_valid;
    assign o_result_ch.kind        = r_out.kind;
    assign o_result_ch.field_id    = r_out.field_id;
    assign o_result_ch.value       = r_out.value;
    assign o_result_ch.error_code  = r_out.error_code;
    assign o_result_ch.sync_offset = r_out.sync_offset;

endmodule

FILE: src/bitstream_header_parser_top.sv
// top level of the bitstream header parser
// i_byte_ch takes the configuration image one byte per word, in file order.
// o_result_ch gives at most one word per byte: a string character with its
// field id, an unknown record warning, the sync offset, or an error code.
// i_cfg_ch writes image_length (index 0) and min_image_length (index 1);
// it is always ready; the user must write it only while no byte is in flight, the block does not enforce this.
// an accepted byte is written into the queue; the parser takes it from the queue
// head when the output register is free, and its result is registered there.
// throughput is one byte per cycle while the queue holds bytes and the receiver does not stall.
// a four-word queue sits between the byte classifier and the parser, so a
// stalled receiver first fills the output register, then the queue, and only
// then drops i_byte_ch.ready; nothing is lost or repeated under stalls.
// after a sync result or an error every further byte is consumed silently.
// reset (synchronous, active low) returns to the magic check at position zero,
// sets image_length to 0 and min_image_length to 4096, and empties the queue.
`timescale 1ns / 1ps
module bitstream_header_parser_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bhp_byte_if.sink     i_byte_ch,
    bhp_cfg_if.sink      i_cfg_ch,
    bhp_result_if.source o_result_ch
);
    import bhp_pkg::*;

    t_queue_status w_q_status;
    t_item         w_push_item;
    t_item         w_head_item;
    logic          w_push;
    logic          w_pop;

    bhp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_ch  (i_byte_ch),
        .i_cfg_ch   (i_cfg_ch),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    bhp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_item   (w_head_item),
        .o_status (w_q_status)
    );

    bhp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (w_q_status),
        .i_item      (w_head_item),
        .o_pop       (w_pop),
        .o_result_ch (o_result_ch)
    );

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.count <= (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_byte_ch.ready |-> w_q_status.full)
        else $error("byte channel stalled with room in queue");

    a_terminal_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_ch.valid && o_result_ch.ready &&
         (o_result_ch.kind == KIND_ERROR || o_result_ch.kind == KIND_SYNC))
        |=> !o_result_ch.valid)
        else $error("result after terminal word");

    a_field_only_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_ch.valid && o_result_ch.kind != KIND_CHAR) |-> o_result_ch.field_id == 2'd0)
        else $error("field id set on non-character word");
`endif

endmodule
